### hdl/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared widths, payload types and work item layout for the RGB to HSV
// converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rhc_pkg;

  // channel and hue widths
  localparam int unsigned CHANNEL_BITS = 8;
  localparam int unsigned HUE_BITS     = 16;

  // hue divisor is 6*(max-min), three bits wider than a channel
  localparam int unsigned HUE_DIV_BITS = CHANNEL_BITS + 3;

  // both dividers run through the same number of stages
  localparam int unsigned PIPE_DEPTH =
      (HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS;

  // default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // input beat
  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } rgb_t;

  // output beat
  typedef struct packed {
    logic [HUE_BITS-1:0]     hue;
    logic [CHANNEL_BITS-1:0] saturation;
    logic [CHANNEL_BITS-1:0] brightness;
  } hsv_t;

  // classified pixel: operands for both long divisions
  typedef struct packed {
    logic [HUE_DIV_BITS-1:0] hue_num;
    logic [HUE_DIV_BITS-1:0] hue_div;
    logic [CHANNEL_BITS-1:0] sat_hi;
    logic [CHANNEL_BITS-1:0] sat_lo;
    logic [CHANNEL_BITS-1:0] sat_div;
    logic [CHANNEL_BITS-1:0] bright;
  } work_t;

endpackage

`default_nettype wire

### hdl/rhc_front.sv
// ----------------------------------------------------------------------------
// rhc_front
// Accepts pixels, finds max/min and the hue sector, and registers the
// division operands for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rhc_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire rhc_pkg::rgb_t in_pixel_i,
  output logic              work_valid_o,
  input  wire logic         work_ready_i,
  output rhc_pkg::work_t    work_o
);
  import rhc_pkg::*;

  typedef enum logic [2:0] {
    SECT_RED   = 3'b001,
    SECT_GREEN = 3'b010,
    SECT_BLUE  = 3'b100
  } sector_e;

  logic [CHANNEL_BITS-1:0]   mx, mn, dlt;
  logic [HUE_DIV_BITS-1:0]   r_x, g_x, b_x, d_x, d2, d4, d6, num;
  logic [2*CHANNEL_BITS-1:0] sat_full;
  sector_e                   sect;
  work_t                     work_d, work_q;
  logic                      vld_q, adv;

  // max, min and spread
  always_comb begin
    mx = in_pixel_i.red;
    mn = in_pixel_i.red;
    if (in_pixel_i.green > mx) mx = in_pixel_i.green;
    if (in_pixel_i.blue  > mx) mx = in_pixel_i.blue;
    if (in_pixel_i.green < mn) mn = in_pixel_i.green;
    if (in_pixel_i.blue  < mn) mn = in_pixel_i.blue;
    dlt = mx - mn;
  end

  // sector pick, ties go red then green
  always_comb begin
    if (mx == in_pixel_i.red) begin
      sect = SECT_RED;
    end else if (mx == in_pixel_i.green) begin
      sect = SECT_GREEN;
    end else begin
      sect = SECT_BLUE;
    end
  end

  assign r_x = HUE_DIV_BITS'(in_pixel_i.red);
  assign g_x = HUE_DIV_BITS'(in_pixel_i.green);
  assign b_x = HUE_DIV_BITS'(in_pixel_i.blue);
  assign d_x = HUE_DIV_BITS'(dlt);
  assign d2  = d_x << 1;
  assign d4  = d_x << 2;
  assign d6  = d4 + d2;

  // hue numerator offset*d + diff, always below 6*d
  always_comb begin
    unique case (sect)
      SECT_RED: begin
        if (in_pixel_i.green >= in_pixel_i.blue) begin
          num = g_x - b_x;
        end else begin
          num = d6 - (b_x - g_x);
        end
      end
      SECT_GREEN: num = d2 + b_x - r_x;
      SECT_BLUE:  num = d4 + r_x - g_x;
      default:    num = '0;
    endcase
  end

  // d*(2^C-1) split into high and low halves for the long division
  assign sat_full = {dlt, {CHANNEL_BITS{1'b0}}} - (2*CHANNEL_BITS)'(dlt);

  // operands; a zero divisor becomes one over a zero numerator
  always_comb begin
    work_d.hue_num = (dlt == '0) ? '0 : num;
    work_d.hue_div = (dlt == '0) ? HUE_DIV_BITS'(1) : d6;
    work_d.sat_hi  = sat_full[2*CHANNEL_BITS-1:CHANNEL_BITS];
    work_d.sat_lo  = sat_full[CHANNEL_BITS-1:0];
    work_d.sat_div = (mx == '0) ? CHANNEL_BITS'(1) : mx;
    work_d.bright  = mx;
  end

  // one register stage toward the queue
  assign adv          = !vld_q || work_ready_i;
  assign in_ready_o   = adv;
  assign work_valid_o = vld_q;
  assign work_o       = work_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      work_q <= work_d;
    end
  end

endmodule

`default_nettype wire

### hdl/rhc_fifo.sv
// ----------------------------------------------------------------------------
// rhc_fifo
// Short queue of classified pixels between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rhc_fifo #(
  parameter int unsigned Depth = rhc_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire rhc_pkg::work_t push_data_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output rhc_pkg::work_t      pop_data_o
);
  import rhc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  work_t             mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = cnt_q != CntW'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### hdl/rhc_div_pipe.sv
// ----------------------------------------------------------------------------
// rhc_div_pipe
// Pipelined restoring divider, one quotient bit per stage. The starting
// remainder must be below the divisor; low dividend bits shift in MSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rhc_div_pipe #(
  parameter int unsigned DivW  = rhc_pkg::HUE_DIV_BITS,
  parameter int unsigned QuoW  = rhc_pkg::HUE_BITS,
  parameter int unsigned Depth = rhc_pkg::PIPE_DEPTH
) (
  input  wire logic            clk_i,
  input  wire logic            adv_i,
  input  wire logic [DivW-1:0] rem_i,
  input  wire logic [QuoW-1:0] low_i,
  input  wire logic [DivW-1:0] div_i,
  output logic      [QuoW-1:0] quo_o
);

  logic [DivW-1:0] rem_q [Depth];
  logic [QuoW-1:0] low_q [Depth];
  logic [DivW-1:0] dv_q  [Depth];
  logic [QuoW-1:0] quo_q [Depth];

  for (genvar k = 0; k < Depth; k++) begin : g_stage
    logic [DivW-1:0] rem_in, rem_nx, dv_in;
    logic [QuoW-1:0] low_in, low_nx, quo_in, quo_nx;

    // stage input
    if (k == 0) begin : g_first
      assign rem_in = rem_i;
      assign low_in = low_i;
      assign dv_in  = div_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign dv_in  = dv_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    // one compare and subtract, or pass through past the last bit
    if (k < QuoW) begin : g_step
      logic [DivW:0] trial;
      logic          ge;
      assign trial  = {rem_in, low_in[QuoW-1]};
      assign ge     = trial >= {1'b0, dv_in};
      assign rem_nx = ge ? DivW'(trial - {1'b0, dv_in}) : DivW'(trial);
      assign low_nx = low_in << 1;
      assign quo_nx = {quo_in[QuoW-2:0], ge};
    end else begin : g_hold
      assign rem_nx = rem_in;
      assign low_nx = low_in;
      assign quo_nx = quo_in;
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k] <= rem_nx;
        low_q[k] <= low_nx;
        dv_q[k]  <= dv_in;
        quo_q[k] <= quo_nx;
      end
    end
  end

  assign quo_o = quo_q[Depth-1];

endmodule

`default_nettype wire

### hdl/rhc_back.sv
// ----------------------------------------------------------------------------
// rhc_back
// Runs the hue and saturation divisions side by side and holds the result
// in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rhc_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           work_valid_i,
  output logic                work_ready_o,
  input  wire rhc_pkg::work_t work_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output rhc_pkg::hsv_t       out_hsv_o
);
  import rhc_pkg::*;

  logic                    adv;
  logic                    vld_q  [PIPE_DEPTH];
  logic [CHANNEL_BITS-1:0] brt_q  [PIPE_DEPTH];
  logic [HUE_BITS-1:0]     hue_quo;
  logic [CHANNEL_BITS-1:0] sat_quo;
  logic                    out_vld_q;
  hsv_t                    out_q;

  // whole pipe moves when the output register is free or being drained
  assign adv          = !out_vld_q || out_ready_i;
  assign work_ready_o = adv;

  // hue: (num << HUE_BITS) / (6*d)
  rhc_div_pipe #(
    .DivW  (HUE_DIV_BITS),
    .QuoW  (HUE_BITS),
    .Depth (PIPE_DEPTH)
  ) u_hue_div (
    .clk_i (clk_i),
    .adv_i (adv),
    .rem_i (work_i.hue_num),
    .low_i ('0),
    .div_i (work_i.hue_div),
    .quo_o (hue_quo)
  );

  // saturation: d*(2^C-1) / max
  rhc_div_pipe #(
    .DivW  (CHANNEL_BITS),
    .QuoW  (CHANNEL_BITS),
    .Depth (PIPE_DEPTH)
  ) u_sat_div (
    .clk_i (clk_i),
    .adv_i (adv),
    .rem_i (work_i.sat_hi),
    .low_i (work_i.sat_lo),
    .div_i (work_i.sat_div),
    .quo_o (sat_quo)
  );

  // valid bits along the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PIPE_DEPTH; k++) begin
        vld_q[k] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= work_valid_i;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
      out_vld_q <= vld_q[PIPE_DEPTH-1];
    end
  end

  // brightness rides along with the divisions
  always_ff @(posedge clk_i) begin
    if (adv) begin
      brt_q[0] <= work_i.bright;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        brt_q[k] <= brt_q[k-1];
      end
      out_q.hue        <= hue_quo;
      out_q.saturation <= sat_quo;
      out_q.brightness <= brt_q[PIPE_DEPTH-1];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_hsv_o   = out_q;

endmodule

`default_nettype wire

### hdl/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// RGB in, hue/saturation/brightness out, one pixel per clock unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   in channel : in_valid_i / in_ready_o, beat is rhc_pkg::rgb_t
//   out channel: out_valid_o / out_ready_i, beat is rhc_pkg::hsv_t
//   Each input beat gives exactly one output beat, in order.
//   Throughput: one pixel per cycle while out_ready_i stays high.
//   Path from input accept to output valid: one front register, the queue
//   storage, PIPE_DEPTH divider stages, one output register.
//   The hue and saturation divisions are restoring dividers producing one
//   quotient bit per stage, so the stage count is the wider quotient.
//   When the receiver stalls, the back end holds and the queue of
//   QueueDepth pixels plus the front register keep taking input until full.
//   Reset clears all valid bits, the queue count and the output register
//   valid; no pixel is in flight afterwards.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_converter #(
  parameter int unsigned QueueDepth = rhc_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire rhc_pkg::rgb_t in_pixel_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output rhc_pkg::hsv_t      out_hsv_o
);
  import rhc_pkg::*;

  logic  fr_valid, fr_ready, bk_valid, bk_ready;
  work_t fr_work, bk_work;

  // classify
  rhc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_pixel_i   (in_pixel_i),
    .work_valid_o (fr_valid),
    .work_ready_i (fr_ready),
    .work_o       (fr_work)
  );

  // decoupling queue
  rhc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_work),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_work)
  );

  // divide and deliver
  rhc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_valid_i (bk_valid),
    .work_ready_o (bk_ready),
    .work_i       (bk_work),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_hsv_o    (out_hsv_o)
  );

endmodule

`default_nettype wire

### hdl/rhc_checker.sv
// ----------------------------------------------------------------------------
// rhc_checker
// Port level checks for the converter: occupancy bound, output hold under
// stall and zero hue on grey output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rhc_checker #(
  parameter int unsigned QueueDepth = rhc_pkg::QUEUE_DEPTH
) (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_o,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire rhc_pkg::hsv_t out_hsv_o
);
  import rhc_pkg::*;

  // front register, queue, divider stages, output register
  localparam int unsigned Capacity = QueueDepth + PIPE_DEPTH + 2;
  localparam int unsigned OccW     = $clog2(Capacity + 1) + 1;

  logic            in_beat, out_beat;
  logic [OccW-1:0] occ_q;

  assign in_beat  = in_valid_i && in_ready_o;
  assign out_beat = out_valid_o && out_ready_i;

  // beats in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (in_beat && !out_beat) begin
      occ_q <= occ_q + OccW'(1);
    end else if (out_beat && !in_beat) begin
      occ_q <= occ_q - OccW'(1);
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_hsv_o))
    else $error("output beat changed under stall");

  // no result without a pixel in flight
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occ_q != '0)
    else $error("output beat without pending input");

  // never more in flight than the storage holds
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(Capacity))
    else $error("too many beats in flight");

  // back pressure only when something is pending
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> occ_q != '0)
    else $error("input stalled while empty");

  // a zero saturation always comes with a zero hue
  a_grey_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_hsv_o.saturation == '0 |-> out_hsv_o.hue == '0)
    else $error("hue set on a grey pixel");

endmodule

bind rgb_to_hsv_converter rhc_checker #(
  .QueueDepth (QueueDepth)
) u_rhc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_hsv_o   (out_hsv_o)
);

`default_nettype wire
